// ===== hw/rtl/chebjac_pkg.sv =====
// Shared types and constants for the Chebyshev Jacobian evaluator.
// Holds the fixed-point widths, register indexes, request codes, sequencer states
// and the multiplier request bundle. Depends on nothing.
package chebjac_pkg;

    localparam int ANG_W      = 32;  // Q4.28 angle
    localparam int COEF_W     = 32;  // Q8.24 coefficient and result
    localparam int SCL_W      = 31;  // unsigned Q7.24 scale
    localparam int DEG_W      = 3;
    localparam int X_W        = 30;  // normalised angle and T_n, Q.28 in [-1, 1]
    localparam int U_W        = 34;  // U_n, Q.28 in [-(n+1), n+1] for orders up to 15
    localparam int D_W        = 26;  // T_n', Q.16
    localparam int S_W        = 38;  // inner sum, Q.24
    localparam int MA_W       = 38;
    localparam int MB_W       = 32;
    localparam int MP_W       = MA_W + MB_W;
    localparam int ACC_W      = 64;  // outer sum, Q.40
    localparam int R_W        = 58;  // high partial product of the scale step
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_A_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A_DEGREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B_DEGREE = 3'd5;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NORM_M,
        S_NORM_P,
        S_BINIT,
        S_D_M,
        S_D_P,
        S_T_M,
        S_T_P,
        S_U_M,
        S_U_P,
        S_IN,
        S_IN_END,
        S_OUT_M,
        S_OUT_P,
        S_HI_M,
        S_HI_P,
        S_LO_M,
        S_LO_P,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } mul_req_t;

endpackage

// ===== hw/rtl/chebjac_mul.sv =====
// Shared signed multiplier with a registered product.
// Every multiplication of the evaluator passes through this unit.
// Depends on chebjac_pkg.
module chebjac_mul
    import chebjac_pkg::*;
(
    input  logic                   clk,
    input  mul_req_t               req,
    output logic signed [MP_W-1:0] prod
);

    logic signed [MA_W-1:0] op_a;
    logic signed [MB_W-1:0] op_b;

    assign op_a = req.a;
    assign op_b = req.b;

    always_ff @(posedge clk)
    begin
        prod <= MP_W'(op_a * op_b);
    end

endmodule

// ===== hw/rtl/chebyshev_2d_jacobian.sv =====
// Jacobian of two two-dimensional Chebyshev fits (pitch and roll) with respect to the motor
// angles a and b. A write transaction (req_type 0) stores one Q8.24 coefficient in the pitch
// or roll table and produces no result. An evaluate transaction (req_type 1)
// normalises both angles, builds T_n and T_n' = n*U_{n-1} by recurrence and sums the four
// partial derivatives, returning one result transaction in saturating Q8.24. All of the work
// runs through one shared multiplier under a sequencer, and the block takes no new input
// while an evaluation is in progress. The normalisation and the two basis recurrences come
// first; the table sums that follow dominate with the defaults, one multiplier pass per
// coefficient per direction. A finished result sits in an output register, so the next
// evaluation may start while it waits.
// Coefficient tables are not cleared by reset and must be written before they are used.
// Depends on chebjac_pkg and chebjac_mul.
module chebyshev_2d_jacobian
    import chebjac_pkg::*;
#(
    parameter int MAX_ORDER = 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic                         table_sel,
    input  logic [2:0]                   row_index,
    input  logic [2:0]                   col_index,
    input  logic signed [COEF_W-1:0]     coeff_value,
    input  logic signed [ANG_W-1:0]      angle_a,
    input  logic signed [ANG_W-1:0]      angle_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COEF_W-1:0]     dpitch_da,
    output logic signed [COEF_W-1:0]     dpitch_db,
    output logic signed [COEF_W-1:0]     droll_da,
    output logic signed [COEF_W-1:0]     droll_db,
    output logic                         saturated,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int NORD  = MAX_ORDER + 1;
    localparam int IW    = $clog2(NORD);
    localparam int AW    = 1 + 2 * IW;
    localparam int DEPTH = 2 * NORD * NORD;

    localparam logic signed [X_W-1:0] ONE_X = X_W'(268435456);

    // Round half up, then arithmetic shift right.
    function automatic logic signed [MP_W-1:0] rshr(input logic signed [MP_W-1:0] v,
                                                    input int unsigned s);
        logic signed [MP_W-1:0] half;
        half = MP_W'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    // Configuration registers.
    logic signed [ANG_W-1:0] a_min_reg, b_min_reg;
    logic [SCL_W-1:0]        a_scale_reg, b_scale_reg;
    logic [DEG_W-1:0]        a_degree_reg, b_degree_reg;

    // Sequencer state.
    state_t        state_reg, state_next;
    logic          ang_reg, ang_next;
    logic [IW-1:0] n_reg, n_next;
    logic          tab_reg, tab_next;
    logic          dir_reg, dir_next;
    logic [IW-1:0] outer_reg, outer_next;
    logic [IW-1:0] inner_reg, inner_next;
    logic          pv_reg;
    logic          out_valid_reg;

    // Datapath registers.
    logic signed [ANG_W-1:0] anga_reg, angb_reg;
    logic signed [X_W-1:0]   x_reg [2];
    logic signed [X_W-1:0]   t_reg [2][NORD];
    logic signed [D_W-1:0]   d_reg [2][NORD];
    logic signed [X_W-1:0]   tp1_reg, tp2_reg;
    logic signed [U_W-1:0]   up1_reg, up2_reg;
    logic signed [S_W-1:0]   s_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [R_W-1:0]   r_reg;
    logic signed [COEF_W-1:0] res_reg [4];
    logic                    sat_reg;
    logic signed [COEF_W-1:0] out_reg [4];
    logic                    out_sat_reg;

    // Coefficient memory: both tables, addressed by table, order along a, order along b.
    logic signed [COEF_W-1:0] mem [DEPTH];
    logic signed [COEF_W-1:0] rd_reg;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic                     wr_en;
    logic [IW+2:0]            row_w, col_w;
    logic [IW-1:0]            ri_next, cj_next;

    logic          in_fire;
    logic          out_load;
    logic [IW-1:0] da, db, outer_lim, inner_lim;
    logic          last_n;

    mul_req_t                mreq;
    logic signed [MP_W-1:0]  prod;

    // Arithmetic results of the current step.
    logic signed [ANG_W-1:0]  ang_cur, min_cur;
    logic [SCL_W-1:0]         scl_norm, scl_fin;
    logic signed [X_W-1:0]    x_cur;
    logic signed [ANG_W:0]    diff;
    logic signed [63:0]       p, pr;
    logic signed [X_W-1:0]    x_new;
    logic                     norm_sat;
    logic signed [39:0]       tw, uw, ulim;
    logic signed [X_W-1:0]    t_new;
    logic signed [U_W-1:0]    u_new;
    logic signed [D_W-1:0]    d_new;
    logic signed [S_W-1:0]    term;
    logic signed [48:0]       acc24;
    logic signed [24:0]       hi;
    logic [23:0]              lo;
    logic signed [59:0]       rf;
    logic signed [COEF_W-1:0] fin_val;
    logic                     fin_sat;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign dpitch_da = out_reg[0];
    assign dpitch_db = out_reg[1];
    assign droll_da  = out_reg[2];
    assign droll_db  = out_reg[3];
    assign saturated = out_sat_reg;

    // A degree above the largest supported order acts as that order.
    assign da = (int'(a_degree_reg) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(a_degree_reg);
    assign db = (int'(b_degree_reg) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(b_degree_reg);
    assign outer_lim = dir_reg ? db : da;
    assign inner_lim = dir_reg ? da : db;
    assign last_n    = (n_reg == IW'(MAX_ORDER));

    // Writes beyond the largest order are dropped.
    assign row_w   = (IW + 3)'(row_index);
    assign col_w   = (IW + 3)'(col_index);
    assign wr_en   = in_fire && (req_type == REQ_WRITE)
                     && (int'(row_index) <= MAX_ORDER) && (int'(col_index) <= MAX_ORDER);
    assign wr_addr = {table_sel, row_w[IW-1:0], col_w[IW-1:0]};

    // The read address follows the counters of the next cycle, so the registered read data
    // always belongs to the coefficient the current counters point at.
    assign ri_next = dir_next ? inner_next : outer_next;
    assign cj_next = dir_next ? outer_next : inner_next;
    assign rd_addr = {tab_next, ri_next, cj_next};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= coeff_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
    end

    chebjac_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    // Operand selection and post-processing of the registered product.
    always_comb
    begin
        ang_cur  = ang_reg ? angb_reg : anga_reg;
        min_cur  = ang_reg ? b_min_reg : a_min_reg;
        scl_norm = ang_reg ? b_scale_reg : a_scale_reg;
        scl_fin  = dir_reg ? b_scale_reg : a_scale_reg;
        x_cur    = x_reg[ang_reg];
        diff     = (ANG_W + 1)'(ang_cur) - (ANG_W + 1)'(min_cur);

        acc24 = 49'((65'(acc_reg) + 65'sd32768) >>> 16);
        hi    = 25'(acc24 >>> 24);
        lo    = acc24[23:0];

        mreq.a = '0;
        mreq.b = '0;
        case (state_reg)
            S_NORM_M:
            begin
                mreq.a = MA_W'(diff);
                mreq.b = MB_W'($signed({1'b0, scl_norm}));
            end
            S_D_M:
            begin
                mreq.a = MA_W'(up1_reg);
                mreq.b = MB_W'($signed({1'b0, n_reg}));
            end
            S_T_M:
            begin
                mreq.a = MA_W'(x_cur);
                mreq.b = MB_W'(tp1_reg);
            end
            S_U_M:
            begin
                mreq.a = MA_W'(up1_reg);
                mreq.b = MB_W'(x_cur);
            end
            S_IN:
            begin
                mreq.a = MA_W'(rd_reg);
                mreq.b = MB_W'(t_reg[~dir_reg][inner_reg]);
            end
            S_OUT_M:
            begin
                mreq.a = MA_W'(s_reg);
                mreq.b = MB_W'(d_reg[dir_reg][outer_reg]);
            end
            S_HI_M:
            begin
                mreq.a = MA_W'(hi);
                mreq.b = MB_W'($signed({1'b0, scl_fin}));
            end
            S_LO_M:
            begin
                mreq.a = MA_W'($signed({1'b0, lo}));
                mreq.b = MB_W'($signed({1'b0, scl_fin}));
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase

        // Normalisation: below the span clamps to -1, above it to +1.
        p        = 64'(prod);
        pr       = (p + 64'sd8388608) >>> 24;
        norm_sat = 1'b0;
        if (p < 64'sd0)
        begin
            x_new    = -ONE_X;
            norm_sat = 1'b1;
        end
        else if (p > (64'sd1 <<< 53))
        begin
            x_new    = ONE_X;
            norm_sat = 1'b1;
        end
        else
        begin
            x_new = X_W'(pr - 64'sd268435456);
        end

        // T_n = 2x*T_{n-1} - T_{n-2}, held within [-1, 1].
        tw = 40'(rshr(prod, 27)) - 40'(tp2_reg);
        if (tw > 40'sd268435456)
        begin
            t_new = ONE_X;
        end
        else if (tw < -40'sd268435456)
        begin
            t_new = -ONE_X;
        end
        else
        begin
            t_new = X_W'(tw);
        end

        // U_n = 2x*U_{n-1} - U_{n-2}, held within [-(n+1), n+1].
        ulim = $signed(40'(n_reg) + 40'd1) <<< 28;
        uw   = 40'(rshr(prod, 27)) - 40'(up2_reg);
        if (uw > ulim)
        begin
            u_new = U_W'(ulim);
        end
        else if (uw < -ulim)
        begin
            u_new = U_W'(-ulim);
        end
        else
        begin
            u_new = U_W'(uw);
        end

        d_new = D_W'(rshr(prod, 12));
        term  = S_W'(rshr(prod, 28));

        // Final scale step: high part exact, low part rounded, then saturated.
        rf      = 60'(r_reg) + 60'(rshr(prod, 24));
        fin_sat = 1'b0;
        if (rf > 60'sd2147483647)
        begin
            fin_val = 32'sh7fffffff;
            fin_sat = 1'b1;
        end
        else if (rf < -60'sd2147483648)
        begin
            fin_val = 32'sh80000000;
            fin_sat = 1'b1;
        end
        else
        begin
            fin_val = COEF_W'(rf);
        end
    end

    // Sequencer: next state and loop counters.
    always_comb
    begin
        state_next = state_reg;
        ang_next   = ang_reg;
        n_next     = n_reg;
        tab_next   = tab_reg;
        dir_next   = dir_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (req_type == REQ_EVAL))
                begin
                    ang_next   = 1'b0;
                    tab_next   = 1'b0;
                    dir_next   = 1'b0;
                    outer_next = '0;
                    inner_next = '0;
                    state_next = S_NORM_M;
                end
            end
            S_NORM_M:
            begin
                state_next = S_NORM_P;
            end
            S_NORM_P:
            begin
                ang_next   = ~ang_reg;
                state_next = ang_reg ? S_BINIT : S_NORM_M;
            end
            S_BINIT:
            begin
                n_next     = IW'(1);
                state_next = S_D_M;
            end
            S_D_M:
            begin
                state_next = S_D_P;
            end
            S_D_P:
            begin
                if (n_reg == IW'(1))
                begin
                    if (last_n)
                    begin
                        ang_next   = ~ang_reg;
                        state_next = ang_reg ? S_IN : S_BINIT;
                    end
                    else
                    begin
                        n_next     = n_reg + IW'(1);
                        state_next = S_D_M;
                    end
                end
                else
                begin
                    state_next = S_T_M;
                end
            end
            S_T_M:
            begin
                state_next = S_T_P;
            end
            S_T_P:
            begin
                state_next = S_U_M;
            end
            S_U_M:
            begin
                state_next = S_U_P;
            end
            S_U_P:
            begin
                if (last_n)
                begin
                    ang_next   = ~ang_reg;
                    state_next = ang_reg ? S_IN : S_BINIT;
                end
                else
                begin
                    n_next     = n_reg + IW'(1);
                    state_next = S_D_M;
                end
            end
            S_IN:
            begin
                if (inner_reg == inner_lim)
                begin
                    inner_next = '0;
                    state_next = S_IN_END;
                end
                else
                begin
                    inner_next = inner_reg + IW'(1);
                end
            end
            S_IN_END:
            begin
                state_next = S_OUT_M;
            end
            S_OUT_M:
            begin
                state_next = S_OUT_P;
            end
            S_OUT_P:
            begin
                if (outer_reg == outer_lim)
                begin
                    outer_next = '0;
                    state_next = S_HI_M;
                end
                else
                begin
                    outer_next = outer_reg + IW'(1);
                    state_next = S_IN;
                end
            end
            S_HI_M:
            begin
                state_next = S_HI_P;
            end
            S_HI_P:
            begin
                state_next = S_LO_M;
            end
            S_LO_M:
            begin
                state_next = S_LO_P;
            end
            S_LO_P:
            begin
                dir_next = ~dir_reg;
                if (dir_reg)
                begin
                    tab_next = ~tab_reg;
                end
                state_next = (dir_reg && tab_reg) ? S_DONE : S_IN;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ang_reg       <= 1'b0;
            n_reg         <= '0;
            tab_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            outer_reg     <= '0;
            inner_reg     <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            a_min_reg     <= '0;
            a_scale_reg   <= 31'd16777216;
            b_min_reg     <= '0;
            b_scale_reg   <= 31'd16777216;
            a_degree_reg  <= 3'd7;
            b_degree_reg  <= 3'd7;
        end
        else
        begin
            state_reg <= state_next;
            ang_reg   <= ang_next;
            n_reg     <= n_next;
            tab_reg   <= tab_next;
            dir_reg   <= dir_next;
            outer_reg <= outer_next;
            inner_reg <= inner_next;
            pv_reg    <= (state_reg == S_IN);

            if ((state_reg == S_DONE) && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_A_MIN:    a_min_reg    <= cfg_data;
                    CFG_A_SCALE:  a_scale_reg  <= cfg_data[SCL_W-1:0];
                    CFG_B_MIN:    b_min_reg    <= cfg_data;
                    CFG_B_SCALE:  b_scale_reg  <= cfg_data[SCL_W-1:0];
                    CFG_A_DEGREE: a_degree_reg <= cfg_data[DEG_W-1:0];
                    CFG_B_DEGREE: b_degree_reg <= cfg_data[DEG_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Datapath registers, loaded according to the step in progress.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (req_type == REQ_EVAL))
                begin
                    anga_reg <= angle_a;
                    angb_reg <= angle_b;
                    sat_reg  <= 1'b0;
                    s_reg    <= '0;
                    acc_reg  <= '0;
                end
            end
            S_NORM_P:
            begin
                x_reg[ang_reg] <= x_new;
                if (norm_sat)
                begin
                    sat_reg <= 1'b1;
                end
            end
            S_BINIT:
            begin
                t_reg[ang_reg][0] <= ONE_X;
                t_reg[ang_reg][1] <= x_cur;
                d_reg[ang_reg][0] <= '0;
                tp2_reg           <= ONE_X;
                tp1_reg           <= x_cur;
                up1_reg           <= U_W'(ONE_X);
            end
            S_D_P:
            begin
                d_reg[ang_reg][n_reg] <= d_new;
                if (n_reg == IW'(1))
                begin
                    up2_reg <= up1_reg;
                    up1_reg <= U_W'(x_cur) <<< 1;
                end
            end
            S_T_P:
            begin
                t_reg[ang_reg][n_reg] <= t_new;
                tp2_reg               <= tp1_reg;
                tp1_reg               <= t_new;
            end
            S_U_P:
            begin
                up2_reg <= up1_reg;
                up1_reg <= u_new;
            end
            S_IN:
            begin
                if (pv_reg)
                begin
                    s_reg <= s_reg + term;
                end
            end
            S_IN_END:
            begin
                s_reg <= s_reg + term;
            end
            S_OUT_P:
            begin
                acc_reg <= acc_reg + ACC_W'(prod);
                s_reg   <= '0;
            end
            S_HI_P:
            begin
                r_reg <= R_W'(prod);
            end
            S_LO_P:
            begin
                res_reg[{tab_reg, dir_reg}] <= fin_val;
                acc_reg                     <= '0;
                if (fin_sat)
                begin
                    sat_reg <= 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_reg[0]  <= res_reg[0];
                    out_reg[1]  <= res_reg[1];
                    out_reg[2]  <= res_reg[2];
                    out_reg[3]  <= res_reg[3];
                    out_sat_reg <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
